FILE: hdl/assert_macros.svh
// Assertion macros for the port-level checker of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, masked while reset is high
`define SMID_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("smid assertion failed");

// Concurrent assertion that stays live through reset
`define SMID_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("smid assertion failed");

`endif

FILE: hdl/smid_pkg.sv
// Shared types and constants for the small matrix inverse and determinant block.
// No dependencies.
package smid_pkg;

   localparam int DEF_FRAC_BITS   = 16;
   localparam int DEF_ENTRY_WIDTH = 32;
   localparam int NUM_ENTRIES     = 9;

   typedef enum logic [1:0] {
      ORDER_NONE  = 2'd0,
      ORDER_ONE   = 2'd1,
      ORDER_TWO   = 2'd2,
      ORDER_THREE = 2'd3
   } order_type;

   // Control that travels with each divider lane
   typedef struct packed {
      logic active;
      logic neg;
   } div_ctrl_type;

   // Adjugate entry k (cofactor of the transposed entry) is m[a]*m[b] - m[c]*m[d] for a full 3x3 matrix
   localparam int COF_IDX [NUM_ENTRIES][4] = '{
      '{4, 8, 5, 7},
      '{2, 7, 1, 8},
      '{1, 5, 2, 4},
      '{5, 6, 3, 8},
      '{0, 8, 2, 6},
      '{2, 3, 0, 5},
      '{3, 7, 4, 6},
      '{1, 6, 0, 7},
      '{0, 4, 1, 3}
   };

endpackage

FILE: hdl/smid_cof_lane.sv
// One cofactor lane: a*b - c*d over two registered stages.
// Depends on smid_pkg.
module smid_cof_lane
   import smid_pkg::*;
#(
   parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
)
(
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [ENTRY_WIDTH-1:0]   a_in,
   input  logic signed [ENTRY_WIDTH-1:0]   b_in,
   input  logic signed [ENTRY_WIDTH-1:0]   c_in,
   input  logic signed [ENTRY_WIDTH-1:0]   d_in,
   output logic signed [2*ENTRY_WIDTH:0]   cof_out
);

   localparam int W = ENTRY_WIDTH;

   logic signed [2*W-1:0] pa_ff;
   logic signed [2*W-1:0] pb_ff;
   logic signed [2*W:0]   cof_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff  <= a_in * b_in;
         pb_ff  <= c_in * d_in;
         cof_ff <= {pa_ff[2*W-1], pa_ff} - {pb_ff[2*W-1], pb_ff};
      end
   end

   assign cof_out = cof_ff;

endmodule

FILE: hdl/smid_det_merge.sv
// Merging stage: determinant as the sum of three entry-by-cofactor products,
// each product split in two narrower multiplies. Depends on smid_pkg.
module smid_det_merge
   import smid_pkg::*;
#(
   parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
)
(
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [ENTRY_WIDTH-1:0]   x_in [3],
   input  logic signed [2*ENTRY_WIDTH:0]   c_in [3],
   output logic signed [3*ENTRY_WIDTH+2:0] det_out
);

   localparam int W  = ENTRY_WIDTH;
   localparam int PW = 2 * W + 1;
   localparam int TW = 3 * W + 2;
   localparam int DW = 3 * W + 3;

   logic signed [PW-1:0] ph_ff [3];
   logic signed [PW-1:0] pl_ff [3];
   logic signed [TW-1:0] t_ff  [3];
   logic signed [DW-1:0] det_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            ph_ff[k] <= x_in[k] * $signed(c_in[k][2*W:W]);
            pl_ff[k] <= x_in[k] * $signed({1'b0, c_in[k][W-1:0]});
            t_ff[k]  <= $signed({ph_ff[k][PW-1], ph_ff[k], {W{1'b0}}})
                        + $signed({{(W+1){pl_ff[k][PW-1]}}, pl_ff[k]});
         end
         det_ff <= $signed({t_ff[0][TW-1], t_ff[0]}) + $signed({t_ff[1][TW-1], t_ff[1]})
                   + $signed({t_ff[2][TW-1], t_ff[2]});
      end
   end

   assign det_out = det_ff;

endmodule

FILE: hdl/smid_div_lane.sv
// One inverse lane: rounded, saturated cofactor * 2^(2*FRAC_BITS) / det,
// restoring division with one quotient bit per stage. Depends on smid_pkg.
module smid_div_lane
   import smid_pkg::*;
#(
   parameter int FRAC_BITS   = DEF_FRAC_BITS,
   parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
)
(
   input  logic                            clock,
   input  logic                            en,
   input  div_ctrl_type                    ctrl_in,
   input  logic signed [2*ENTRY_WIDTH:0]   cof_in,
   input  logic signed [3*ENTRY_WIDTH+2:0] det_in,
   output logic [ENTRY_WIDTH-1:0]          q_out,
   output logic                            clip_out
);

   localparam int W    = ENTRY_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int CW   = 2 * W + 1;
   localparam int DW   = 3 * W + 3;
   localparam int NW   = CW + 2 * F;
   localparam int SW   = DW + W;
   localparam int XW   = ((NW > SW) ? NW : SW) + 1;
   localparam int LAST = W + 1;

   logic [CW-1:0] cmag;
   logic [DW-1:0] dmag;

   logic [XW-1:0]  rem_ff  [0:LAST];
   logic [DW-1:0]  dv_ff   [0:LAST];
   div_ctrl_type   ctrl_ff [0:LAST];
   logic [W-1:0]   q_ff    [1:LAST];
   logic           ovf_ff  [1:LAST];

   logic           rnd;
   logic [W:0]     qr;
   logic [W:0]     lim;
   logic           sat;
   logic [W-1:0]   q_in;
   logic [W-1:0]   qout_ff;
   logic           clip_in;
   logic           clip_ff;

   assign cmag = cof_in[CW-1] ? (~cof_in) + CW'(1) : cof_in;
   assign dmag = det_in[DW-1] ? (~det_in) + DW'(1) : det_in;

   // magnitudes, then the overflow check against d * 2^W
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= XW'(cmag) << (2 * F);
         dv_ff[0]   <= dmag;
         ctrl_ff[0] <= ctrl_in;
         rem_ff[1]  <= rem_ff[0];
         dv_ff[1]   <= dv_ff[0];
         ctrl_ff[1] <= ctrl_ff[0];
         q_ff[1]    <= '0;
         ovf_ff[1]  <= rem_ff[0] >= (XW'(dv_ff[0]) << W);
      end
   end

   for (genvar k = 2; k <= LAST; k++) begin : g_bit
      localparam int B = LAST - k;
      logic [XW-1:0] trial;
      logic          take;

      assign trial = XW'(dv_ff[k-1]) << B;
      assign take  = rem_ff[k-1] >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? rem_ff[k-1] - trial : rem_ff[k-1];
            q_ff[k]    <= q_ff[k-1] | (take ? (W'(1) << B) : W'(0));
            dv_ff[k]   <= dv_ff[k-1];
            ctrl_ff[k] <= ctrl_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
         end
      end
   end

   // round half away from zero, then clamp to the signed entry range
   assign rnd = {rem_ff[LAST], 1'b0} >= (XW+1)'(dv_ff[LAST]);
   assign qr  = {1'b0, q_ff[LAST]} + (W+1)'(rnd);
   assign lim = ctrl_ff[LAST].neg ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
   assign sat = ovf_ff[LAST] || (qr > lim);

   always_comb begin
      if (!ctrl_ff[LAST].active) begin
         q_in    = '0;
         clip_in = 1'b0;
      end else if (sat) begin
         q_in    = ctrl_ff[LAST].neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         clip_in = 1'b1;
      end else begin
         q_in    = ctrl_ff[LAST].neg ? (~qr[W-1:0]) + W'(1) : qr[W-1:0];
         clip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qout_ff <= q_in;
         clip_ff <= clip_in;
      end
   end

   assign q_out    = qout_ff;
   assign clip_out = clip_ff;

endmodule

FILE: hdl/small_matrix_inverse_det.sv
// A request passes the cofactor lanes, the determinant merge and the divider lanes, which
// find one quotient bit per stage, before it shows on rsp.
// Throughput: one request per cycle; the whole pipeline holds while a response waits.
// Reset clears the stage valid bits and the response valid; data registers keep junk.
module small_matrix_inverse_det
   import smid_pkg::*;
#(
   parameter  int FRAC_BITS   = DEF_FRAC_BITS,
   parameter  int ENTRY_WIDTH = DEF_ENTRY_WIDTH,
   localparam int REQ_W = ((2 + NUM_ENTRIES * ENTRY_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((10 * ENTRY_WIDTH + 2 + 7) / 8) * 8
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // order, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero pad
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // q00, q01, q02, q10, q11, q12, q20, q21, q22, determinant_out, singular, clipped, pad
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int W   = ENTRY_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int CW  = 2 * W + 1;
   localparam int DW  = 3 * W + 3;
   localparam int LAT = W + 8;

   localparam logic signed [W-1:0] ONE  = {{(W-1){1'b0}}, 1'b1};
   localparam logic signed [W-1:0] ZERO = '0;

   logic en;
   order_type req_order;
   logic signed [W-1:0] m [NUM_ENTRIES];
   logic signed [W-1:0] opa [NUM_ENTRIES];
   logic signed [W-1:0] opb [NUM_ENTRIES];
   logic signed [W-1:0] opc [NUM_ENTRIES];
   logic signed [W-1:0] opd [NUM_ENTRIES];

   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;
   order_type      ord_ff [0:4];
   logic signed [W-1:0] e0_ff [0:1][3];

   logic signed [CW-1:0] cof2 [NUM_ENTRIES];
   logic signed [CW-1:0] cof3_ff [NUM_ENTRIES];
   logic signed [CW-1:0] cof4_ff [NUM_ENTRIES];
   logic signed [CW-1:0] cof5_ff [NUM_ENTRIES];

   logic signed [W-1:0]  dx [3];
   logic signed [CW-1:0] dc [3];
   logic signed [DW-1:0] det5;
   logic                 zero5;

   logic [W-1:0] lane_q    [NUM_ENTRIES];
   logic         lane_clip [NUM_ENTRIES];

   logic [DW-1:0] dmag_ff;
   logic          dneg1_ff;
   logic          sing1_ff;
   order_type     dord_ff;
   logic [DW-1:0] dq_ff;
   logic [DW-1:0] dq_in;
   logic          dneg2_ff;
   logic          sing2_ff;
   logic [W-1:0]  dval_in;
   logic          dclip_in;
   logic [W-1:0]  dval_ff  [1:W+1];
   logic          dclip_ff [1:W+1];
   logic          sing_ff  [1:W+1];

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff;
   logic [RSP_W-1:0] rsp_data_in;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign req_order  = order_type'(req_tdata[1:0]);

   // lane operands; smaller orders reuse the lanes with unit and zero factors
   always_comb begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         m[k]   = req_tdata[2 + W * k +: W];
      end
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         opa[k] = m[COF_IDX[k][0]];
         opb[k] = m[COF_IDX[k][1]];
         opc[k] = m[COF_IDX[k][2]];
         opd[k] = m[COF_IDX[k][3]];
      end
      unique case (req_order) inside
         ORDER_THREE: begin
         end
         ORDER_TWO: begin
            opa[0] = m[4];  opb[0] = ONE;  opc[0] = ZERO; opd[0] = ZERO;
            opa[1] = ZERO;  opb[1] = ZERO; opc[1] = m[1]; opd[1] = ONE;
            opa[3] = ZERO;  opb[3] = ZERO; opc[3] = m[3]; opd[3] = ONE;
            opa[4] = m[0];  opb[4] = ONE;  opc[4] = ZERO; opd[4] = ZERO;
         end
         ORDER_ONE, ORDER_NONE: begin
            opa[0] = ONE;   opb[0] = ONE;  opc[0] = ZERO; opd[0] = ZERO;
            opa[8] = m[0];  opb[8] = ONE;  opc[8] = ZERO; opd[8] = ZERO;
         end
      endcase
   end

   for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cof
      smid_cof_lane #(.ENTRY_WIDTH(W)) u_cof (
         .clock   (clock),
         .en      (en),
         .a_in    (opa[k]),
         .b_in    (opb[k]),
         .c_in    (opc[k]),
         .d_in    (opd[k]),
         .cof_out (cof2[k])
      );
   end

   assign vld_in = {vld_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ord_ff[0] <= req_order;
         for (int i = 1; i < 5; i++) begin
            ord_ff[i] <= ord_ff[i-1];
         end
         for (int j = 0; j < 3; j++) begin
            e0_ff[0][j] <= m[j];
            e0_ff[1][j] <= e0_ff[0][j];
         end
         for (int k = 0; k < NUM_ENTRIES; k++) begin
            cof3_ff[k] <= cof2[k];
            cof4_ff[k] <= cof3_ff[k];
            cof5_ff[k] <= cof4_ff[k];
         end
      end
   end

   // first-row expansion for order three; else det is the last lane, or zero for order zero
   always_comb begin
      if (ord_ff[1] == ORDER_THREE) begin
         dx[0] = e0_ff[1][0];
         dx[1] = e0_ff[1][1];
         dx[2] = e0_ff[1][2];
         dc[0] = cof2[0];
      end else begin
         dx[0] = (ord_ff[1] == ORDER_NONE) ? ZERO : ONE;
         dx[1] = ZERO;
         dx[2] = ZERO;
         dc[0] = cof2[8];
      end
      dc[1] = cof2[3];
      dc[2] = cof2[6];
   end

   smid_det_merge #(.ENTRY_WIDTH(W)) u_det (
      .clock   (clock),
      .en      (en),
      .x_in    (dx),
      .c_in    (dc),
      .det_out (det5)
   );

   assign zero5 = (det5 == '0);

   for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_div
      localparam int R = k / 3;
      localparam int C = k % 3;
      div_ctrl_type ctrl;

      assign ctrl.active = (2'(R) < ord_ff[4]) && (2'(C) < ord_ff[4]) && !zero5;
      assign ctrl.neg    = cof5_ff[k][CW-1] ^ det5[DW-1];

      smid_div_lane #(.FRAC_BITS(F), .ENTRY_WIDTH(W)) u_div (
         .clock    (clock),
         .en       (en),
         .ctrl_in  (ctrl),
         .cof_in   (cof5_ff[k]),
         .det_in   (det5),
         .q_out    (lane_q[k]),
         .clip_out (lane_clip[k])
      );
   end

   // determinant output: drop (order-1) fraction fields with rounding, then clamp
   always_comb begin
      unique case (dord_ff) inside
         ORDER_THREE:          dq_in = (dmag_ff >> (2 * F)) + DW'(dmag_ff[2*F-1]);
         ORDER_TWO:            dq_in = (dmag_ff >> F) + DW'(dmag_ff[F-1]);
         ORDER_ONE, ORDER_NONE: dq_in = dmag_ff;
      endcase
   end

   always_comb begin
      if (dneg2_ff ? (dq_ff > {{(DW-W){1'b0}}, 1'b1, {(W-1){1'b0}}})
                   : (dq_ff > {{(DW-W+1){1'b0}}, {(W-1){1'b1}}})) begin
         dval_in  = dneg2_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         dclip_in = 1'b1;
      end else begin
         dval_in  = dneg2_ff ? (~dq_ff[W-1:0]) + W'(1) : dq_ff[W-1:0];
         dclip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dmag_ff     <= det5[DW-1] ? (~det5) + DW'(1) : det5;
         dneg1_ff    <= det5[DW-1];
         sing1_ff    <= zero5;
         dord_ff     <= ord_ff[4];
         dq_ff       <= dq_in;
         dneg2_ff    <= dneg1_ff;
         sing2_ff    <= sing1_ff;
         dval_ff[1]  <= dval_in;
         dclip_ff[1] <= dclip_in;
         sing_ff[1]  <= sing2_ff;
         // hold alongside the divider lanes
         for (int i = 2; i <= W + 1; i++) begin
            dval_ff[i]  <= dval_ff[i-1];
            dclip_ff[i] <= dclip_ff[i-1];
            sing_ff[i]  <= sing_ff[i-1];
         end
      end
   end

   always_comb begin
      logic clip_any;
      clip_any    = dclip_ff[W+1];
      rsp_data_in = '0;
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         rsp_data_in[W*k +: W] = lane_q[k];
         clip_any              = clip_any | lane_clip[k];
      end
      rsp_data_in[9*W +: W] = dval_ff[W+1];
      rsp_data_in[10*W]     = sing_ff[W+1];
      rsp_data_in[10*W+1]   = clip_any;
   end

   assign rsp_valid_in = en ? vld_ff[LAT-1] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: hdl/smid_checker.sv
// Port-level checker for small_matrix_inverse_det, bound to the top level.
// Depends on smid_pkg and assert_macros.svh.
`include "assert_macros.svh"
module smid_checker
   import smid_pkg::*;
#(
   parameter  int ENTRY_WIDTH = DEF_ENTRY_WIDTH,
   localparam int RSP_W = ((10 * ENTRY_WIDTH + 2 + 7) / 8) * 8
)
(
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   localparam int W = ENTRY_WIDTH;

   logic            rsp_wait;
   logic            rsp_sing;
   logic            rsp_clip;
   logic [10*W-1:0] rsp_body;

   assign rsp_wait = rsp_tvalid && !rsp_tready;
   assign rsp_sing = rsp_tvalid && rsp_tdata[10*W];
   assign rsp_clip = rsp_tdata[10*W+1];
   assign rsp_body = rsp_tdata[10*W-1:0];

   // a waiting response holds still
   `SMID_ASSERT(a_rsp_hold, clock, reset, rsp_wait |=> rsp_tvalid && $stable(rsp_tdata))

   // a singular result carries no inverse, no determinant and no clip
   `SMID_ASSERT(a_singular, clock, reset, rsp_sing |-> !rsp_clip && (rsp_body == '0))

   // requests stall only behind a held response
   `SMID_ASSERT(a_ready, clock, reset, !req_tready |-> rsp_wait)

   // nothing leaves straight after reset
   `SMID_ASSERT_NR(a_reset, clock, reset |=> !rsp_tvalid)

endmodule

bind small_matrix_inverse_det smid_checker #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_smid_checker (.*);

FILE: test/smid_checker.sv
// Checker for the small matrix inverse and determinant block: watches req and rsp,
// predicts each response from the accepted request and compares field by field.
// Depends on smid_pkg for the order codes and the cofactor index table.
module smid_scoreboard
   import smid_pkg::*;
#(
   parameter int REQ_W = 296,
   parameter int RSP_W = 328
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               fail_count,
   output int               pending,
   output int               checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = DEF_FRAC_BITS;
   localparam int EW = DEF_ENTRY_WIDTH;

   typedef logic signed [191:0] wide_type;

   typedef struct {
      logic signed [EW-1:0] inv [NUM_ENTRIES];
      logic signed [EW-1:0] det;
      logic                 singular;
      logic                 clipped;
   } inverse_type;

   inverse_type inverse_q [$];

   // Quotient rounded to nearest, ties away from zero
   function automatic wide_type round_div(input wide_type num, input wide_type den);
      logic [191:0] an, ad, q, r;
      logic         neg;
      neg = (num < 0) != (den < 0);
      an  = (num < 0) ? -num : num;
      ad  = (den < 0) ? -den : den;
      q   = an / ad;
      r   = an % ad;
      if ((r << 1) >= ad) q = q + 1;
      return neg ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [EW-1:0] clamp(input wide_type v, inout logic clip);
      wide_type hi, lo;
      hi = (wide_type'(1) <<< (EW - 1)) - 1;
      lo = -(wide_type'(1) <<< (EW - 1));
      if (v > hi) begin
         clip = 1'b1;
         return hi[EW-1:0];
      end
      if (v < lo) begin
         clip = 1'b1;
         return lo[EW-1:0];
      end
      return v[EW-1:0];
   endfunction

   function automatic inverse_type predict_inverse(input logic [REQ_W-1:0] d);
      inverse_type res;
      wide_type    e [NUM_ENTRIES];
      wide_type    adj [NUM_ENTRIES];
      wide_type    det;
      order_type   n;
      logic        clip;
      n    = order_type'(d[1:0]);
      clip = 1'b0;
      foreach (res.inv[k]) res.inv[k] = '0;
      res.det      = '0;
      res.singular = 1'b0;
      res.clipped  = 1'b0;
      if (n == ORDER_NONE) begin
         res.singular = 1'b1;
         return res;
      end
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         e[k]   = $signed(d[2 + EW*k +: EW]);
         adj[k] = '0;
      end
      case (n)
         ORDER_ONE: begin
            det    = e[0];
            adj[0] = 1;
         end
         ORDER_TWO: begin
            det    = e[0]*e[4] - e[1]*e[3];
            adj[0] = e[4];
            adj[1] = -e[1];
            adj[3] = -e[3];
            adj[4] = e[0];
         end
         default: begin
            for (int k = 0; k < NUM_ENTRIES; k++)
               adj[k] = e[COF_IDX[k][0]]*e[COF_IDX[k][1]] - e[COF_IDX[k][2]]*e[COF_IDX[k][3]];
            det = e[0]*adj[0] + e[1]*adj[3] + e[2]*adj[6];
         end
      endcase
      res.det = clamp(round_div(det, wide_type'(1) <<< ((int'(n) - 1) * FB)), clip);
      if (det == 0) begin
         res.singular = 1'b1;
      end else begin
         for (int r = 0; r < int'(n); r++)
            for (int c = 0; c < int'(n); c++)
               res.inv[r*3+c] = clamp(round_div(adj[r*3+c] <<< (2*FB), det), clip);
      end
      res.clipped = clip;
      return res;
   endfunction

   always @(posedge clock) begin
      inverse_type exp_r;
      logic signed [EW-1:0] got;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
         checked    <= 0;
         pending    <= 0;
         inverse_q.delete();
      end else begin
         if (req_tvalid && req_tready) inverse_q.push_back(predict_inverse(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            checked <= checked + 1;
            if (inverse_q.size() == 0) begin
               $error("response with no request outstanding");
               errs++;
            end else begin
               exp_r = inverse_q.pop_front();
               for (int k = 0; k < NUM_ENTRIES; k++) begin
                  got = rsp_tdata[EW*k +: EW];
                  if (got !== exp_r.inv[k]) begin
                     $error("q%0d%0d expected %0d got %0d", k/3, k%3, exp_r.inv[k], got);
                     errs++;
                  end
               end
               got = rsp_tdata[EW*9 +: EW];
               if (got !== exp_r.det) begin
                  $error("determinant_out expected %0d got %0d", exp_r.det, got);
                  errs++;
               end
               if (rsp_tdata[EW*10] !== exp_r.singular) begin
                  $error("singular expected %0b got %0b", exp_r.singular, rsp_tdata[EW*10]);
                  errs++;
               end
               if (rsp_tdata[EW*10+1] !== exp_r.clipped) begin
                  $error("clipped expected %0b got %0b", exp_r.clipped, rsp_tdata[EW*10+1]);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending    <= inverse_q.size();
      end
   end

endmodule

FILE: test/tb_top.sv
// Top of the small matrix inverse and determinant testbench: clock, reset,
// request stimulus, response back-pressure and verdict. Depends on smid_pkg,
// smid_scoreboard and the block itself.
module tb_top;
   import smid_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EW      = DEF_ENTRY_WIDTH;
   localparam int REQ_W   = ((2 + NUM_ENTRIES * EW + 7) / 8) * 8;
   localparam int RSP_W   = ((10 * EW + 2 + 7) / 8) * 8;
   localparam int N_RAND  = 1400;
   localparam int IDLE_LIMIT = 5000;
   localparam logic signed [EW-1:0] ONE  = 32'sh0001_0000;
   localparam logic signed [EW-1:0] VMAX = 32'sh7FFF_FFFF;
   localparam logic signed [EW-1:0] VMIN = 32'sh8000_0000;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   int               fail_count, pending, checked;
   int               sent;
   int               idle_cycles;

   small_matrix_inverse_det i_dut (.*);

   smid_scoreboard #(.REQ_W(REQ_W), .RSP_W(RSP_W)) i_checker (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic logic signed [EW-1:0] rand_entry();
      int p;
      p = $urandom_range(99);
      if (p < 50) return $signed($urandom_range(1 << 19)) - (1 << 18);
      if (p < 70) return $signed($urandom_range(1 << 13)) - (1 << 12);
      if (p < 75) return 0;
      return $urandom;
   endfunction

   task automatic send_matrix(input order_type n, input logic signed [EW-1:0] m [NUM_ENTRIES]);
      int gap;
      logic [REQ_W-1:0] d;
      d = '0;
      d[1:0] = n;
      for (int k = 0; k < NUM_ENTRIES; k++) d[2 + EW*k +: EW] = m[k];
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_fill(input order_type n, input logic signed [EW-1:0] v);
      logic signed [EW-1:0] m [NUM_ENTRIES];
      foreach (m[k]) m[k] = v;
      send_matrix(n, m);
   endtask

   task automatic send_diag(input order_type n, input logic signed [EW-1:0] v);
      logic signed [EW-1:0] m [NUM_ENTRIES];
      foreach (m[k]) m[k] = (k % 4 == 0) ? v : 0;
      send_matrix(n, m);
   endtask

   // Back-pressure, with one long hold-off once 500 requests have been sent
   initial begin
      int hold;
      bit held;
      rsp_tready = 1'b0;
      held = 0;
      @(negedge reset);
      forever begin
         if (!held && sent >= 500) begin
            held = 1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1) ? 1 + $urandom_range(20) : 1) @(posedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      logic signed [EW-1:0] m [NUM_ENTRIES];
      order_type n;
      int p, dup;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      sent       = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every order, identity, extremes, singular, clipping
      send_fill(ORDER_NONE, 0);
      send_fill(ORDER_NONE, VMAX);
      send_diag(ORDER_ONE, ONE);
      send_diag(ORDER_TWO, ONE);
      send_diag(ORDER_THREE, ONE);
      send_diag(ORDER_ONE, 0);
      send_diag(ORDER_ONE, VMAX);
      send_diag(ORDER_ONE, VMIN);
      send_diag(ORDER_ONE, 1);
      send_diag(ORDER_ONE, -1);
      send_diag(ORDER_ONE, 32'sd3);
      send_diag(ORDER_TWO, VMAX);
      send_diag(ORDER_TWO, VMIN);
      send_diag(ORDER_THREE, VMAX);
      send_diag(ORDER_THREE, VMIN);
      send_diag(ORDER_THREE, 32'sd256);
      send_diag(ORDER_TWO, 32'sh0000_8000);
      send_fill(ORDER_TWO, ONE);
      send_fill(ORDER_THREE, VMIN);
      send_fill(ORDER_THREE, -1);
      m = '{ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 10*ONE};
      send_matrix(ORDER_THREE, m);
      m = '{VMAX, VMIN, VMAX, VMIN, VMAX, VMIN, VMAX, VMIN, VMIN};
      send_matrix(ORDER_THREE, m);
      m = '{2*ONE, ONE, 0, ONE, 2*ONE, 0, 0, 0, 3*ONE};
      send_matrix(ORDER_TWO, m);

      for (int i = 0; i < N_RAND; i++) begin
         p = $urandom_range(99);
         n = (p < 3) ? ORDER_NONE : (p < 18) ? ORDER_ONE : (p < 43) ? ORDER_TWO : ORDER_THREE;
         foreach (m[k]) m[k] = rand_entry();
         // Copy one row onto another now and then; order three goes singular
         if ($urandom_range(9) == 0) begin
            dup = $urandom_range(2);
            for (int c = 0; c < 3; c++) m[((dup + 1) % 3)*3 + c] = m[dup*3 + c];
         end
         send_matrix(n, m);
      end
      req_tvalid <= 1'b0;

      // let the last request reach the checker's count first
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("tb: %0d matrices of order 0 to 3 sent, %0d responses checked,", sent, checked);
      $display("tb: including singular, saturating and back-pressured cases");
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
